// ----- rtl/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

	// Size of the line buffer; the usable line is one entry shorter.
	localparam int unsigned LINE_DEPTH = 256;
	localparam int unsigned CAP_RAW    = LINE_DEPTH - 1;
	localparam logic [7:0]  LIMIT_CAP  = (CAP_RAW > 255) ? 8'hFF : CAP_RAW[7:0];

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic [7:0]  MAX_LENGTH_RST    = 8'hFF;
	localparam logic [31:0] TIMEOUT_TICKS_RST = 32'h0;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_FAULT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_NEWLINE = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_FULL    = 2'd2,
		ST_ERROR   = 2'd3
	} status_t;

	typedef enum logic {
		REG_MAX_LENGTH    = 1'b0,
		REG_TIMEOUT_TICKS = 1'b1
	} reg_index_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic signed [7:0] fault_code;
	} item_t;

	// One item's results: a single beat, or the three-beat erase sequence.
	typedef struct packed {
		logic        has_result;
		logic        erase_burst;
		logic        echo_valid;
		logic [7:0]  echo_byte;
		logic        store_valid;
		logic [7:0]  store_index;
		logic [7:0]  store_byte;
		logic        line_done;
		logic [7:0]  line_length;
		status_t     end_status;
		logic signed [7:0] end_error;
	} group_t;

endpackage

// ----- rtl/sle_line_ctrl.sv -----
// ----------------------------------------------------------------------------
// sle_line_ctrl
// Line state, configuration registers and per-item result decode.
// ----------------------------------------------------------------------------
module sle_line_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data,
	input  sle_pkg::item_t item,
	input  logic           take,
	output sle_pkg::group_t grp
);
	import sle_pkg::*;

	logic [7:0]  max_length_q;
	logic [31:0] timeout_ticks_q;
	logic        active_q;
	logic [7:0]  count_q;
	logic [31:0] elapsed_q;

	logic        active_d;
	logic [7:0]  count_d;
	logic [31:0] elapsed_d;
	logic [7:0]  limit;
	logic [7:0]  count_inc;
	logic [31:0] elapsed_inc;
	logic [7:0]  fault_fix;

	assign limit       = (max_length_q < LIMIT_CAP) ? max_length_q : LIMIT_CAP;
	assign count_inc   = count_q + 8'd1;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	// non-negative receiver codes are reported as -1
	assign fault_fix   = item.fault_code[7] ? item.fault_code : 8'hFF;

	always_comb begin
		grp       = '0;
		active_d  = active_q;
		count_d   = count_q;
		elapsed_d = elapsed_q;
		unique case (item.kind)
			KIND_START: begin
				count_d   = '0;
				elapsed_d = '0;
				if (limit == 8'd0) begin
					active_d       = 1'b0;
					grp.has_result = 1'b1;
					grp.line_done  = 1'b1;
					grp.end_status = ST_FULL;
				end else begin
					active_d = 1'b1;
				end
			end
			KIND_BYTE: begin
				if (active_q) begin
					if (item.data_byte == CH_CR || item.data_byte == CH_LF) begin
						active_d        = 1'b0;
						grp.has_result  = 1'b1;
						grp.echo_valid  = 1'b1;
						grp.echo_byte   = CH_LF;
						grp.store_valid = 1'b1;
						grp.store_index = count_q;
						grp.line_done   = 1'b1;
						grp.line_length = count_q;
						grp.end_status  = ST_NEWLINE;
					end else if (item.data_byte == CH_BS) begin
						if (count_q != 8'd0) begin
							count_d         = count_q - 8'd1;
							grp.has_result  = 1'b1;
							grp.erase_burst = 1'b1;
							grp.echo_valid  = 1'b1;
							grp.echo_byte   = CH_BS;
						end
					end else begin
						count_d         = count_inc;
						grp.has_result  = 1'b1;
						grp.echo_valid  = 1'b1;
						grp.echo_byte   = item.data_byte;
						grp.store_valid = 1'b1;
						grp.store_index = count_q;
						grp.store_byte  = item.data_byte;
						if (count_inc >= limit) begin
							active_d        = 1'b0;
							grp.line_done   = 1'b1;
							grp.line_length = count_inc;
							grp.end_status  = ST_FULL;
						end
					end
				end
			end
			KIND_TICK: begin
				if (active_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > timeout_ticks_q) begin
						active_d        = 1'b0;
						grp.has_result  = 1'b1;
						grp.store_valid = 1'b1;
						grp.store_index = count_q;
						grp.line_done   = 1'b1;
						grp.line_length = count_q;
						grp.end_status  = ST_TIMEOUT;
					end
				end
			end
			KIND_FAULT: begin
				if (active_q) begin
					active_d        = 1'b0;
					grp.has_result  = 1'b1;
					grp.echo_valid  = 1'b1;
					grp.echo_byte   = CH_LF;
					grp.store_valid = 1'b1;
					grp.store_index = count_q;
					grp.line_done   = 1'b1;
					grp.line_length = count_q;
					grp.end_status  = ST_ERROR;
					grp.end_error   = fault_fix;
				end
			end
			default: begin
				grp = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q    <= MAX_LENGTH_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_MAX_LENGTH:    max_length_q    <= cfg_data[7:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default:           max_length_q    <= max_length_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			count_q   <= '0;
			elapsed_q <= '0;
		end else if (take) begin
			active_q  <= active_d;
			count_q   <= count_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

// ----- rtl/serial_line_editor_unit.sv -----
// ----------------------------------------------------------------------------
// serial_line_editor_unit
// Serial command line collector with echo and backspace editing.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one beat per event: start line, received
// byte, timer tick or read error. Output channel (out_valid/out_stall): one
// beat per result, with echo, buffer store and line end information; last
// marks the final beat caused by an input.
// A beat enters an input register and is decoded against the line state into
// the result register once that register is free. Events with a single result
// or none sustain one beat per cycle while out_stall is low; a backspace that
// erases a character produces three output beats and holds the input until
// the last is taken. Events that produce nothing leave the output untouched.
// When the receiver stalls, the result register holds, then the input
// register fills and in_stall rises; nothing is dropped.
// Reset empties both registers, leaves the block idle (no line open), count
// and tick counter at zero, max_length at 255 and timeout_ticks at zero.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module serial_line_editor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic signed [7:0] fault_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        echo_valid,
	output logic [7:0]  echo_byte,
	output logic        store_valid,
	output logic [7:0]  store_index,
	output logic [7:0]  store_byte,
	output logic        line_done,
	output logic [7:0]  line_length,
	output logic [1:0]  end_status,
	output logic signed [7:0] end_error,
	output logic        last
);
	import sle_pkg::*;

	logic    s1_valid_q;
	item_t   item_s1;
	group_t  grp;
	group_t  out_q;
	logic    out_valid_q;
	logic [1:0] beat_q;
	logic    out_last;
	logic    pop;
	logic    out_free;
	logic    s1_fire;
	logic    in_take;

	assign out_last = !out_q.erase_burst || (beat_q == 2'd2);
	assign pop      = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || (pop && out_last);
	assign s1_fire  = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{kind: kind_t'(kind), data_byte: data_byte, fault_code: fault_code};
		end
	end

	sle_line_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_s1),
		.take      (s1_fire),
		.grp       (grp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= '0;
		end else if (s1_fire && grp.has_result) begin
			out_valid_q <= 1'b1;
			beat_q      <= '0;
		end else if (pop) begin
			if (out_last) begin
				out_valid_q <= 1'b0;
			end else begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && grp.has_result) begin
			out_q <= grp;
		end
	end

	// erase sequence: BS, space, BS
	assign out_valid   = out_valid_q;
	assign echo_valid  = out_q.echo_valid;
	assign echo_byte   = (out_q.erase_burst && beat_q == 2'd1) ? CH_SP : out_q.echo_byte;
	assign store_valid = out_q.store_valid;
	assign store_index = out_q.store_index;
	assign store_byte  = out_q.store_byte;
	assign line_done   = out_q.line_done;
	assign line_length = out_q.line_length;
	assign end_status  = out_q.end_status;
	assign end_error   = out_q.end_error;
	assign last        = out_last;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("input stalled with empty input register");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.line_done |-> out_last && !out_q.erase_burst)
		else $error("line end on a non-final beat");

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (beat_q == 2'd0 || (out_q.erase_burst && beat_q != 2'd3)))
		else $error("beat counter out of range");

	a_burst_advance: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !out_last |=> out_valid_q && beat_q == $past(beat_q) + 2'd1)
		else $error("erase sequence did not advance");

endmodule
